// ----- rtl/interval_overlap_index_assert.svh -----
// Assertion macros for the interval overlap index
`ifndef INTERVAL_OVERLAP_INDEX_ASSERT_SVH
`define INTERVAL_OVERLAP_INDEX_ASSERT_SVH

// Clocked assertion with reset disable
`define IOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked next-cycle implication with reset disable
`define IOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

// ----- rtl/ioi_pkg.sv -----
// Package: types, codes and defaults for the interval overlap index
package ioi_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 4096;
  localparam int unsigned INDEX_BINS_DEF    = 4096;
  localparam int unsigned BIN_SHIFT_DEF     = 13;
  localparam int unsigned POS_W             = 31;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_BUILD  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_NO_INDEX  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_BLD_CLR,
    S_BLD_RD,
    S_BLD_WAIT,
    S_BLD_MARK,
    S_Q_PICK_RD,
    S_Q_PICK,
    S_Q_BACK_RD,
    S_Q_BACK,
    S_Q_SCAN_RD,
    S_Q_SCAN,
    S_DONE
  } state_e;

endpackage

// ----- rtl/ioi_if.sv -----
// Channel interfaces: operation input and result output
interface ioi_in_if;
  import ioi_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] end_pos;
  modport source (output valid, operation, start_pos, end_pos, input ready);
  modport sink   (input valid, operation, start_pos, end_pos, output ready);
endinterface

interface ioi_out_if;
  logic       valid;
  logic       ready;
  logic       overlap_found;
  logic [1:0] status;
  modport source (output valid, overlap_found, status, input ready);
  modport sink   (input valid, overlap_found, status, output ready);
endinterface

// ----- rtl/interval_overlap_index.sv -----
// Top level: sorted interval store, linear bin index and overlap query
//
//  channel | dir | payload                              | transaction
//  in_i    | in  | operation, start_pos, end_pos        | valid & ready
//  out_o   | out | overlap_found, status                | valid & ready
//
// One item at a time, paced by each memory's read and write ports; in_i.ready only in idle.
// Clear, rejected insert, stale or empty-table query go straight to the done state. Insert
// reads and shifts larger entries up one compare at a time. Build clears every bin, then
// reads each entry and marks its unmarked bins. Query picks a bin, walks back, then scans.
// The result waits in an output register; a stalled out_o holds the next result in the
// done state. Reset clears only the state, counters and flags.
module interval_overlap_index #(
  parameter int unsigned MAX_INTERVALS = ioi_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned INDEX_BINS    = ioi_pkg::INDEX_BINS_DEF,
  parameter int unsigned BIN_SHIFT     = ioi_pkg::BIN_SHIFT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ioi_in_if.sink        in_i,
  ioi_out_if.source     out_o
);
  import ioi_pkg::*;

  localparam int unsigned AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned BW    = (INDEX_BINS > 1) ? $clog2(INDEX_BINS) : 1;
  localparam int unsigned LEN_W = $clog2(INDEX_BINS + 1);
  localparam int unsigned KEY_W = 2 * POS_W;

  function automatic logic [BW-1:0] bin_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] b;
    b = p >> BIN_SHIFT;
    if (32'(b) > 32'(INDEX_BINS - 1)) return BW'(INDEX_BINS - 1);
    else return b[BW-1:0];
  endfunction

  // memories
  logic [KEY_W-1:0] store_mem [MAX_INTERVALS];
  logic [AW:0]      bin_mem   [INDEX_BINS];

  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [KEY_W-1:0] st_wdata, st_rdata_q;
  logic             bin_we;
  logic [BW-1:0]    bin_waddr, bin_raddr;
  logic [AW:0]      bin_wdata, bin_rdata_q;

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bin_we) bin_mem[bin_waddr] <= bin_wdata;
    bin_rdata_q <= bin_mem[bin_raddr];
  end

  // control and datapath registers
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             valid_q, valid_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0] hi_q, hi_d;
  logic [BW-1:0]    eb_q, eb_d;
  logic [BW-1:0]    sweep_q, sweep_d;
  logic [POS_W-1:0] s_q, s_d, e_q, e_d;
  logic             res_found_q, res_found_d;
  status_e          res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  status_e          out_status_q, out_status_d;

  logic             in_acc;
  logic             out_free;
  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] pos_m1;
  logic [POS_W-1:0] rd_start, rd_end;
  logic [BW-1:0]    rd_sb, rd_eb, q_bin, q_pick;
  logic [LEN_W-1:0] q_n, eb_p1;
  logic             bin_used;
  logic [AW-1:0]    bin_idx;
  logic             ins_bad, ins_full, q_skip, ins_shift;

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign key       = {s_q, e_q};
  assign pos_m1    = pos_q - 1'b1;
  assign rd_start  = st_rdata_q[KEY_W-1:POS_W];
  assign rd_end    = st_rdata_q[POS_W-1:0];
  assign rd_sb     = bin_of(rd_start);
  assign rd_eb     = bin_of(rd_end);
  assign q_bin     = bin_of(s_q);
  assign q_pick    = (LEN_W'(q_bin) >= len_q) ? BW'(len_q - 1'b1) : q_bin;
  assign q_n       = (LEN_W'(q_bin) < len_q) ? LEN_W'(q_bin) : len_q;
  assign eb_p1     = LEN_W'(eb_q) + 1'b1;
  assign bin_used  = bin_rdata_q[AW];
  assign bin_idx   = bin_rdata_q[AW-1:0];
  assign ins_bad   = in_i.end_pos <= in_i.start_pos;
  assign ins_full  = count_q == CNT_W'(MAX_INTERVALS);
  assign q_skip    = (count_q == '0) || (len_q == '0);
  assign ins_shift = st_rdata_q > key;

  assign in_i.ready          = state_q == S_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.overlap_found = out_found_q;
  assign out_o.status        = out_status_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e'(in_i.operation))
            OP_CLEAR:  state_d = S_DONE;
            OP_INSERT: state_d = (ins_bad || ins_full) ? S_DONE : S_INS_RD;
            OP_BUILD:  state_d = S_BLD_CLR;
            OP_QUERY:  state_d = (!valid_q || q_skip) ? S_DONE : S_Q_PICK_RD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INS_RD:    state_d = (pos_q == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP:   state_d = ins_shift ? S_INS_RD : S_DONE;
      S_BLD_CLR:   state_d = (sweep_q == BW'(INDEX_BINS - 1)) ? S_BLD_RD : S_BLD_CLR;
      S_BLD_RD:    state_d = (pos_q == count_q) ? S_DONE : S_BLD_WAIT;
      S_BLD_WAIT:  state_d = S_BLD_MARK;
      S_BLD_MARK:  state_d = (cur_q <= LEN_W'(eb_q)) ? S_BLD_MARK : S_BLD_RD;
      S_Q_PICK_RD: state_d = S_Q_PICK;
      S_Q_PICK:    state_d = bin_used ? S_Q_SCAN_RD : S_Q_BACK_RD;
      S_Q_BACK_RD: state_d = (cur_q == '0) ? S_Q_SCAN_RD : S_Q_BACK;
      S_Q_BACK:    state_d = bin_used ? S_Q_SCAN_RD : S_Q_BACK_RD;
      S_Q_SCAN_RD: state_d = (pos_q >= count_q) ? S_DONE : S_Q_SCAN;
      S_Q_SCAN: begin
        if ((rd_start >= e_q) || (rd_end > s_q)) state_d = S_DONE;
        else state_d = S_Q_SCAN_RD;
      end
      S_DONE:      state_d = out_free ? S_IDLE : S_DONE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    count_d      = count_q;
    len_d        = len_q;
    valid_d      = valid_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    hi_d         = hi_q;
    eb_d         = eb_q;
    sweep_d      = sweep_q;
    s_d          = s_q;
    e_d          = e_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    st_we        = 1'b0;
    st_waddr     = pos_q[AW-1:0];
    st_wdata     = key;
    st_raddr     = pos_q[AW-1:0];
    bin_we       = 1'b0;
    bin_waddr    = sweep_q;
    bin_wdata    = '0;
    bin_raddr    = q_pick;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          s_d          = in_i.start_pos;
          e_d          = in_i.end_pos;
          res_found_d  = 1'b0;
          res_status_d = ST_OK;
          pos_d        = count_q;
          sweep_d      = '0;
          case (op_e'(in_i.operation))
            OP_CLEAR: begin
              count_d = '0;
              len_d   = '0;
              valid_d = 1'b0;
            end
            OP_INSERT: begin
              if (ins_bad) res_status_d = ST_BAD_RANGE;
              else if (ins_full) res_status_d = ST_FULL;
            end
            OP_BUILD: begin
              pos_d = '0;
              hi_d  = '0;
            end
            OP_QUERY: begin
              if (!valid_q) res_status_d = ST_NO_INDEX;
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        st_raddr = pos_m1[AW-1:0];
        if (pos_q == '0) begin
          st_we   = 1'b1;
          count_d = count_q + 1'b1;
          valid_d = 1'b0;
        end
      end
      S_INS_CMP: begin
        st_we = 1'b1;
        if (ins_shift) begin
          st_wdata = st_rdata_q;
          pos_d    = pos_m1;
        end else begin
          count_d = count_q + 1'b1;
          valid_d = 1'b0;
        end
      end
      S_BLD_CLR: begin
        bin_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      S_BLD_RD: begin
        if (pos_q == count_q) begin
          len_d   = (count_q == '0) ? '0 : eb_p1;
          valid_d = 1'b1;
        end
      end
      S_BLD_WAIT: begin
        eb_d  = rd_eb;
        cur_d = (LEN_W'(rd_sb) > hi_q) ? LEN_W'(rd_sb) : hi_q;
      end
      S_BLD_MARK: begin
        if (cur_q <= LEN_W'(eb_q)) begin
          bin_we    = 1'b1;
          bin_waddr = cur_q[BW-1:0];
          bin_wdata = {1'b1, pos_q[AW-1:0]};
          cur_d     = cur_q + 1'b1;
        end else begin
          if (eb_p1 > hi_q) hi_d = eb_p1;
          pos_d = pos_q + 1'b1;
        end
      end
      S_Q_PICK_RD: begin
        cur_d = q_n;
      end
      S_Q_PICK, S_Q_BACK: begin
        if (bin_used) pos_d = CNT_W'(bin_idx);
      end
      S_Q_BACK_RD: begin
        bin_raddr = BW'(cur_q - 1'b1);
        if (cur_q == '0) pos_d = '0;
        else cur_d = cur_q - 1'b1;
      end
      S_Q_SCAN_RD: ;
      S_Q_SCAN: begin
        if (rd_start < e_q) begin
          if (rd_end > s_q) res_found_d = 1'b1;
          else pos_d = pos_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      len_q       <= len_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    hi_q         <= hi_d;
    eb_q         <= eb_d;
    sweep_q      <= sweep_d;
    s_q          <= s_d;
    e_q          <= e_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
  end

endmodule

// ----- rtl/ioi_checker.sv -----
// Port checker for the interval overlap index, bound to the top level
`include "interval_overlap_index_assert.svh"

module ioi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_found_i,
  input logic [1:0] out_status_i
);
  import ioi_pkg::*;

  logic [2:0] out_data;

  assign out_data = {out_found_i, out_status_i};

  `IOI_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `IOI_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data), "result changed")
  `IOI_ASSERT(a_found_ok, out_valid_i && out_found_i |-> out_status_i == ST_OK, "found with error")
  `IOI_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "ready after accept")

endmodule

bind interval_overlap_index ioi_checker u_ioi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_found_i  (out_o.overlap_found),
  .out_status_i (out_o.status)
);

// ----- test/interval_overlap_index_tb.sv -----
// Testbench for interval_overlap_index: directed, random and back-pressure tests
module interval_overlap_index_tb;
  import ioi_pkg::*;

  localparam int unsigned N_ENT     = MAX_INTERVALS_DEF;
  localparam int unsigned N_BINS    = INDEX_BINS_DEF;
  localparam int unsigned SHIFT     = BIN_SHIFT_DEF;
  localparam logic [30:0] POS_MAX   = 31'h7FFF_FFFF;
  localparam int unsigned CYC_LIMIT = 4_000_000;

  typedef struct packed {
    logic    found;
    status_e status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ioi_in_if  in_ch ();
  ioi_out_if out_ch ();

  interval_overlap_index dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state
  logic [61:0] iv_store [N_ENT];
  int unsigned iv_count;
  int unsigned bin_first [N_BINS];
  bit          bin_used [N_BINS];
  int unsigned idx_len;
  bit          idx_valid;

  answer_t     answer_q [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned n_sent, n_checked, n_errors, n_found, n_status [4];
  int unsigned cycles;
  int unsigned hold_reqs;

  function automatic int unsigned bin_of(logic [30:0] p);
    int unsigned b;
    b = 32'(p >> SHIFT);
    return (b > N_BINS - 1) ? N_BINS - 1 : b;
  endfunction

  function automatic answer_t predict_answer(op_e op, logic [30:0] s, logic [30:0] e);
    answer_t     a;
    logic [61:0] key;
    int unsigned pos, sb, eb, q, pick, off, n;
    a.found  = 1'b0;
    a.status = ST_OK;
    case (op)
      OP_CLEAR: begin
        iv_count  = 0;
        idx_len   = 0;
        idx_valid = 0;
      end
      OP_INSERT: begin
        if (e <= s) a.status = ST_BAD_RANGE;
        else if (iv_count >= N_ENT) a.status = ST_FULL;
        else begin
          key = {s, e};
          pos = iv_count;
          while (pos > 0 && iv_store[pos-1] > key) begin
            iv_store[pos] = iv_store[pos-1];
            pos--;
          end
          iv_store[pos] = key;
          iv_count++;
          idx_valid = 0;
        end
      end
      OP_BUILD: begin
        foreach (bin_used[b]) begin
          bin_used[b]  = 0;
          bin_first[b] = 0;
        end
        idx_len = 0;
        for (int unsigned i = 0; i < iv_count; i++) begin
          sb = bin_of(iv_store[i][61:31]);
          eb = bin_of(iv_store[i][30:0]);
          for (int unsigned b = sb; b <= eb; b++)
            if (!bin_used[b]) begin
              bin_used[b]  = 1;
              bin_first[b] = i;
            end
          idx_len = eb + 1;
        end
        idx_valid = 1;
      end
      default: begin
        if (!idx_valid) a.status = ST_NO_INDEX;
        else if (iv_count != 0 && idx_len != 0) begin
          q    = bin_of(s);
          pick = (q >= idx_len) ? idx_len - 1 : q;
          off  = 0;
          if (bin_used[pick]) off = bin_first[pick];
          else begin
            n = (q < idx_len) ? q : idx_len;
            while (n > 0) begin
              n--;
              if (bin_used[n]) begin
                off = bin_first[n];
                break;
              end
            end
          end
          for (int unsigned i = off; i < iv_count; i++) begin
            if (iv_store[i][61:31] >= e) break;
            if (iv_store[i][30:0] > s) begin
              a.found = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    return a;
  endfunction

  task automatic send_item(op_e op, logic [30:0] s, logic [30:0] e);
    answer_t a;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.start_pos <= s;
    in_ch.end_pos   <= e;
    do @(posedge clk_i); while (!in_ch.ready);
    a = predict_answer(op, s, e);
    answer_q.push_back(a);
    n_sent++;
  endtask

  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (answer_q.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic logic [30:0] rand_pos();
    case ($urandom_range(3))
      0: return 31'($urandom_range(0, 1 << 16));
      1: return 31'($urandom_range(0, 1 << 26));
      2: return 31'($urandom);
      default: return POS_MAX - 31'($urandom_range(0, 1 << 14));
    endcase
  endfunction

  function automatic logic [30:0] rand_end(logic [30:0] s);
    logic [31:0] e;
    case ($urandom_range(3))
      0: e = s + $urandom_range(1, 64);
      1: e = s + $urandom_range(1, 1 << 15);
      2: e = s + $urandom_range(1, 1 << 24);
      default: e = s + ($urandom & 32'h7FFF_FFFF);
    endcase
    return (e > POS_MAX) ? POS_MAX : e[30:0];
  endfunction

  // result checker
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (answer_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result found=%0b status=%0d",
                                     out_ch.overlap_found, out_ch.status);
      end else begin
        want = answer_q.pop_front();
        n_checked++;
        n_found += want.found;
        n_status[want.status]++;
        if (out_ch.overlap_found !== want.found || out_ch.status !== want.status) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d: expected found=%0b status=%0d, got found=%0b status=%0d",
                     n_checked, want.found, want.status, out_ch.overlap_found, out_ch.status);
        end
      end
    end
  end

  // result sink with random stalls and a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned hold_left;
    int unsigned hold_seen;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_seen = hold_reqs;
    end else begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_QUERY, '0, 31'd10);              // stale index
    send_item(OP_INSERT, 31'd100, 31'd100);       // empty interval
    send_item(OP_INSERT, POS_MAX, '0);            // reversed interval
    send_item(OP_BUILD, '0, '0);
    send_item(OP_QUERY, '0, POS_MAX);             // empty table
    send_item(OP_INSERT, 31'(10 << SHIFT), 31'((10 << SHIFT) + 50));
    send_item(OP_BUILD, '0, '0);
    send_item(OP_QUERY, 31'(2 << SHIFT), 31'(11 << SHIFT)); // no used bin below, scan from 0
    send_item(OP_QUERY, '0, 31'd5);
    send_item(OP_INSERT, '0, 31'd1);
    send_item(OP_INSERT, POS_MAX - 1'b1, POS_MAX);
    send_item(OP_INSERT, 31'd7, 31'd20);
    send_item(OP_QUERY, '0, 31'd1);               // index stale after insert
    send_item(OP_BUILD, '0, '0);
    send_item(OP_QUERY, 31'(5 << SHIFT), 31'((5 << SHIFT) + 9));  // walk back over empty bins
    send_item(OP_QUERY, POS_MAX - 1'b1, POS_MAX); // clamped bin
    send_item(OP_QUERY, 31'd30, 31'd8);           // reversed query
    send_item(OP_QUERY, 31'd15, 31'd15);          // empty query
    send_item(OP_QUERY, 31'd1, 31'd7);
    send_item(OP_QUERY, 31'd20, 31'(10 << SHIFT));
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_QUERY, '0, 31'd1);
  endtask

  task automatic test_random_phase(int unsigned items);
    int unsigned done_items, k;
    logic [30:0] s;
    done_items = 0;
    while (done_items < items) begin
      if ($urandom_range(9) < 8) begin
        send_item(OP_CLEAR, '0, '0);
        k = $urandom_range(0, 24);
        for (int unsigned i = 0; i < k; i++) begin
          s = rand_pos();
          if ($urandom_range(15) == 0) send_item(OP_INSERT, s, 31'(s - $urandom_range(0, 3)));
          else send_item(OP_INSERT, s, rand_end(s));
        end
        if ($urandom_range(7) == 0) send_item(OP_QUERY, rand_pos(), rand_pos());
        send_item(OP_BUILD, '0, '0);
        for (int unsigned i = 0; i < 12; i++) begin
          s = rand_pos();
          send_item(OP_QUERY, s, ($urandom_range(9) == 0) ? rand_pos() : rand_end(s));
        end
        done_items += k + 14;
      end else begin
        k = $urandom_range(4, 12);
        for (int unsigned i = 0; i < k; i++)
          send_item(op_e'($urandom_range(3)), 31'($urandom), 31'($urandom));
        done_items += k;
      end
    end
  endtask

  task automatic test_backpressure();
    logic [30:0] s;
    hold_reqs++;
    for (int unsigned i = 0; i < 12; i++) begin
      s = rand_pos();
      send_item(($urandom_range(1) != 0) ? OP_INSERT : OP_QUERY, s, rand_end(s));
    end
    pause_until_drained();
    send_item(OP_BUILD, '0, '0);
    send_item(OP_QUERY, '0, POS_MAX);
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.start_pos <= '0;
    in_ch.end_pos   <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(400);
    send_idle_pct = 68;
    test_random_phase(400);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    test_random_phase(400);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    test_random_phase(400);
    test_backpressure();

    in_ch.valid <= 1'b0;
    wait (answer_q.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("%0d transactions sent, %0d results checked (%0d overlaps, ok %0d, full %0d,",
             n_sent, n_checked, n_found, n_status[ST_OK], n_status[ST_FULL]);
    $display("  bad range %0d, no index %0d), %0d cycles, %0d mismatches",
             n_status[ST_BAD_RANGE], n_status[ST_NO_INDEX], cycles, n_errors);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ioi_pkg.sv
rtl/ioi_if.sv
rtl/interval_overlap_index.sv
rtl/ioi_checker.sv
test/interval_overlap_index_tb.sv
